// ----- rtl/spatial_hash_cell_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// spatial_hash_cell_table_unit_assert
// Assertion macros shared by the cell table RTL.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_HASH_CELL_TABLE_UNIT_ASSERT_SVH
`define SPATIAL_HASH_CELL_TABLE_UNIT_ASSERT_SVH

// Assert that a condition implies a consequence in the same cycle.
`define SHCT_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define SHCT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/shct_pkg.sv -----
// ----------------------------------------------------------------------------
// shct_pkg
// Types and constants of the spatial cell hash table.
// ----------------------------------------------------------------------------
package shct_pkg;

    localparam int DEF_BUCKETS     = 4096;
    localparam int DEF_NODES       = 1024;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int CFG_WIDTH       = 3;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GRID_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GRID_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GRID_Z = 2'd2;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    // unused code, behaves as a lookup
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  node_index;
        logic [11:0] bucket_index;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HEAD,
        S_WALK,
        S_CHECK,
        S_FREE_RD,
        S_COMMIT,
        S_OUT
    } state_t;

endpackage

// ----- rtl/shct_ram.sv -----
// ----------------------------------------------------------------------------
// shct_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module shct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/spatial_hash_cell_table_unit.sv -----
// ----------------------------------------------------------------------------
// spatial_hash_cell_table_unit
// Chained hash table of 3D cell coordinates over a fixed node pool.
// ----------------------------------------------------------------------------
// One request at a time. A request passes through the idle, head read,
// check, commit and output states, plus a walk state per chain node
// compared, a further commit step when it writes back (insert of a new cell
// or remove of a present one) and a free read state when the new node is
// popped off the free list; writes go through the single port of each RAM,
// one per cycle. After reset a clearing pass sweeps the bucket head RAM, one
// bucket per cycle, during which no request is taken. The result sits in an
// output register, so the next request is taken while it waits; that
// request holds in the head read stage until the result beat has left.
`include "spatial_hash_cell_table_unit_assert.svh"

module spatial_hash_cell_table_unit
    import shct_pkg::*;
#(
    parameter int BUCKETS     = DEF_BUCKETS,
    parameter int NODES       = DEF_NODES,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  req_t                       in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output rsp_t                       out_data
);

    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int CW = 3 * COORD_WIDTH;

    logic [CFG_WIDTH-1:0] gx_reg, gy_reg, gz_reg;
    state_t state_reg, state_next;

    logic [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic [1:0]             act_reg;
    logic [BW-1:0]          bkt_reg;
    logic [BW:0]            clr_reg;
    logic                   prev_ok_reg;
    logic [NW-1:0]          prev_reg, cur_reg, newn_reg;
    logic                   cur_ok_reg;
    logic [NW:0]            cur_link_reg;
    logic                   free_ok_reg;
    logic [NW-1:0]          free_idx_reg;
    logic [NW:0]            fresh_reg;
    logic [NW:0]            step_reg;
    logic [1:0]             wb_reg;
    logic                   got_reg;
    logic                   out_valid_reg;
    rsp_t                   out_reg;

    // head RAM
    logic          h_we;
    logic [BW-1:0] h_addr;
    logic [NW:0]   h_wdata, h_rdata;
    // node coordinate RAM
    logic          c_we;
    logic [NW-1:0] c_addr;
    logic [CW-1:0] c_wdata, c_rdata;
    // node link RAM
    logic          l_we;
    logic [NW-1:0] l_addr;
    logic [NW:0]   l_wdata, l_rdata;

    shct_ram #(.WIDTH(NW + 1), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
    shct_ram #(.WIDTH(CW), .DEPTH(NODES)) u_coords (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));
    shct_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_links (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));

    // bucket hash from the input beat
    logic [COORD_WIDTH-1:0] ix, iy, iz;
    logic [23:0]            hx, hy, hz, hsum;
    logic [BW-1:0]          in_bkt;

    always_comb
    begin
        ix = COORD_WIDTH'($unsigned(32'(in_data.cell_x)));
        iy = COORD_WIDTH'($unsigned(32'(in_data.cell_y)));
        iz = COORD_WIDTH'($unsigned(32'(in_data.cell_z)));
        hx = 24'(ix[6:0]) & ((24'd1 << gx_reg) - 24'd1);
        hy = 24'(iy[6:0]) & ((24'd1 << gy_reg) - 24'd1);
        hz = 24'(iz[6:0]) & ((24'd1 << gz_reg) - 24'd1);
        hsum = hx | (hy << gx_reg) | (hz << (5'(gx_reg) + 5'(gy_reg)));
        in_bkt = BW'(hsum);
    end

    logic idle, in_acc, out_acc, match, pool_ok, hold;
    assign idle      = (state_reg == S_IDLE);
    assign in_stall  = !idle;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_acc   = out_valid_reg && !out_stall;
    assign hold      = out_valid_reg && out_stall;
    assign match     = (c_rdata == {x_reg, y_reg, z_reg});
    assign pool_ok   = free_ok_reg || (fresh_reg < (NW+1)'(NODES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg <= 3'd4;
            gy_reg <= 3'd4;
            gz_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_X: gx_reg <= cfg_data;
                CFG_GRID_Y: gy_reg <= cfg_data;
                CFG_GRID_Z: gz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and RAM controls
    always_comb
    begin
        state_next = state_reg;
        h_we = 1'b0; h_addr = bkt_reg; h_wdata = '0;
        c_we = 1'b0; c_addr = cur_reg; c_wdata = {x_reg, y_reg, z_reg};
        l_we = 1'b0; l_addr = cur_reg; l_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                h_we = 1'b1;
                h_addr = BW'(clr_reg);
                if (clr_reg == (BW+1)'(BUCKETS - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                h_addr = in_bkt;
                if (in_acc) state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // head data valid now; fetch first node
                c_addr = NW'(h_rdata);
                l_addr = NW'(h_rdata);
                state_next = h_rdata[NW] ? S_WALK : S_CHECK;
                // hold until the previous result beat has left
                if (hold) state_next = S_HEAD;
            end
            S_WALK:
            begin
                // node data now valid for cur_reg
                c_addr = NW'(l_rdata);
                l_addr = NW'(l_rdata);
                if (match || !l_rdata[NW] || step_reg == (NW+1)'(NODES - 1))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                l_addr = free_idx_reg;
                if (act_reg == ACT_INSERT && !(cur_ok_reg) && free_ok_reg)
                    state_next = S_FREE_RD;
                else
                    state_next = S_COMMIT;
            end
            S_FREE_RD:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = S_OUT;
                if (cur_ok_reg && act_reg == ACT_REMOVE)
                begin
                    if (wb_reg == 2'd0)
                    begin
                        state_next = S_COMMIT;
                        l_addr = prev_reg;
                        l_wdata = cur_link_reg;
                        if (prev_ok_reg) l_we = 1'b1;
                        else
                        begin
                            h_we = 1'b1;
                            h_wdata = cur_link_reg;
                        end
                    end
                    else
                    begin
                        l_we = 1'b1;
                        l_addr = cur_reg;
                        l_wdata = {free_ok_reg, free_idx_reg};
                    end
                end
                else if (got_reg)
                begin
                    if (wb_reg == 2'd0)
                    begin
                        state_next = S_COMMIT;
                        c_we = 1'b1;
                        c_addr = newn_reg;
                        l_we = 1'b1;
                        l_addr = newn_reg;
                        l_wdata = '0;
                    end
                    else
                    begin
                        l_addr = prev_reg;
                        l_wdata = {1'b1, newn_reg};
                        if (prev_ok_reg) l_we = 1'b1;
                        else
                        begin
                            h_we = 1'b1;
                            h_wdata = {1'b1, newn_reg};
                        end
                    end
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            free_ok_reg   <= 1'b0;
            free_idx_reg  <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            wb_reg        <= '0;
            got_reg       <= 1'b0;
            cur_ok_reg    <= 1'b0;
            prev_ok_reg   <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_acc) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 1'b1;
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        act_reg <= in_data.action;
                        x_reg <= ix; y_reg <= iy; z_reg <= iz;
                        bkt_reg <= in_bkt;
                        prev_ok_reg <= 1'b0;
                        prev_reg <= '0;
                        step_reg <= '0;
                        wb_reg <= '0;
                    end
                end
                S_HEAD:
                begin
                    cur_ok_reg <= h_rdata[NW];
                    cur_reg <= NW'(h_rdata);
                    cur_link_reg <= h_rdata;
                end
                S_WALK:
                begin
                    cur_link_reg <= l_rdata;
                    if (!match)
                    begin
                        // advance along the chain
                        prev_ok_reg <= 1'b1;
                        prev_reg <= cur_reg;
                        cur_reg <= NW'(l_rdata);
                        cur_ok_reg <= l_rdata[NW] && step_reg != (NW+1)'(NODES - 1);
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_CHECK:
                begin
                    // take a node from the free list first, else from the pool
                    got_reg <= 1'b0;
                    if (!cur_ok_reg && act_reg == ACT_INSERT && pool_ok)
                    begin
                        got_reg <= 1'b1;
                        if (free_ok_reg)
                            newn_reg <= free_idx_reg;
                        else
                        begin
                            newn_reg <= NW'(fresh_reg);
                            fresh_reg <= fresh_reg + 1'b1;
                        end
                    end
                end
                S_FREE_RD:
                begin
                    // pop the free list
                    free_ok_reg <= l_rdata[NW];
                    free_idx_reg <= NW'(l_rdata);
                    wb_reg <= 2'd0;
                    newn_reg <= free_idx_reg;
                end
                S_COMMIT:
                begin
                    if (wb_reg == 2'd0) wb_reg <= 2'd1;
                    if (state_next == S_OUT)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.bucket_index <= 12'(bkt_reg);
                        out_reg.node_index <= '0;
                        if (cur_ok_reg)
                        begin
                            out_reg.status <= ST_FOUND;
                            out_reg.node_index <= 10'(cur_reg);
                            if (act_reg == ACT_REMOVE)
                            begin
                                free_ok_reg <= 1'b1;
                                free_idx_reg <= cur_reg;
                            end
                        end
                        else if (got_reg)
                        begin
                            out_reg.status <= ST_CREATED;
                            out_reg.node_index <= 10'(newn_reg);
                        end
                        else if (act_reg == ACT_INSERT)
                        begin
                            out_reg.status <= ST_FULL;
                        end
                        else
                        begin
                            out_reg.status <= ST_ABSENT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `SHCT_ASSERT_IMPL(a_stall_busy, clk, rst_n, !idle, in_stall)
    `SHCT_ASSERT_IMPL(a_fresh_bound, clk, rst_n, 1'b1, fresh_reg <= (NW+1)'(NODES))
    `SHCT_ASSERT_NEXT(a_accept_head, clk, rst_n, in_acc, state_reg == S_HEAD)

endmodule

// ----- test/tb_spatial_hash_cell_table_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spatial_hash_cell_table_unit
// Self-checking bench for the spatial cell hash table. A queue of requests
// feeds a clocked driver, a clocked monitor checks every response beat
// against a behavioral table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_spatial_hash_cell_table_unit;
    import shct_pkg::*;

    localparam int NBUCKETS   = DEF_BUCKETS;
    localparam int NNODES     = DEF_NODES;
    localparam int WATCHDOG   = 20000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    req_t                       in_data;
    logic                       out_valid;
    logic                       out_stall;
    rsp_t                       out_data;

    spatial_hash_cell_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // table model
    logic [9:0]  head_node [NBUCKETS];
    logic        head_live [NBUCKETS];
    logic [15:0] coord_x [NNODES];
    logic [15:0] coord_y [NNODES];
    logic [15:0] coord_z [NNODES];
    logic [9:0]  next_node [NNODES];
    logic        next_live [NNODES];
    logic [9:0]  free_node;
    logic        free_live;
    int          fresh_used;
    logic [2:0]  grid_log2 [3];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   errors;
    int   idle_cycles;
    int   accepted_reqs;
    int   checked_rsps;
    int   full_seen;

    function automatic logic [11:0] bucket_of(logic [15:0] x, logic [15:0] y,
                                              logic [15:0] z);
        logic [31:0] h;
        int gx;
        int gy;
        int gz;
        gx = grid_log2[0];
        gy = grid_log2[1];
        gz = grid_log2[2];
        h = (32'(x) & ((32'd1 << gx) - 1))
            | ((32'(y) & ((32'd1 << gy) - 1)) << gx)
            | ((32'(z) & ((32'd1 << gz) - 1)) << (gx + gy));
        return h[11:0];
    endfunction

    function automatic rsp_t table_access(req_t r);
        rsp_t        res;
        logic [11:0] b;
        logic        prev_ok;
        logic [9:0]  prev;
        logic        cur_ok;
        logic [9:0]  cur;
        logic [9:0]  n;
        logic        got;
        int          steps;
        b = bucket_of(r.cell_x, r.cell_y, r.cell_z);
        res.status = ST_ABSENT;
        res.node_index = '0;
        res.bucket_index = b;
        prev_ok = 1'b0;
        prev = '0;
        cur_ok = head_live[b];
        cur = head_node[b];
        steps = 0;
        while (cur_ok && steps < NNODES && !(coord_x[cur] == r.cell_x
               && coord_y[cur] == r.cell_y && coord_z[cur] == r.cell_z))
        begin
            prev_ok = 1'b1;
            prev = cur;
            cur_ok = next_live[cur];
            cur = next_node[cur];
            steps++;
        end
        if (cur_ok && coord_x[cur] == r.cell_x && coord_y[cur] == r.cell_y
            && coord_z[cur] == r.cell_z)
        begin
            res.status = ST_FOUND;
            res.node_index = cur;
            if (r.action == ACT_REMOVE)
            begin
                if (prev_ok)
                begin
                    next_live[prev] = next_live[cur];
                    next_node[prev] = next_node[cur];
                end
                else
                begin
                    head_live[b] = next_live[cur];
                    head_node[b] = next_node[cur];
                end
                next_live[cur] = free_live;
                next_node[cur] = free_node;
                free_live = 1'b1;
                free_node = cur;
            end
        end
        else if (r.action == ACT_INSERT)
        begin
            got = 1'b0;
            n = '0;
            if (free_live)
            begin
                n = free_node;
                free_live = next_live[n];
                free_node = next_node[n];
                got = 1'b1;
            end
            else if (fresh_used < NNODES)
            begin
                n = 10'(fresh_used);
                fresh_used++;
                got = 1'b1;
            end
            if (got)
            begin
                coord_x[n] = r.cell_x;
                coord_y[n] = r.cell_y;
                coord_z[n] = r.cell_z;
                next_live[n] = 1'b0;
                next_node[n] = '0;
                if (prev_ok)
                begin
                    next_live[prev] = 1'b1;
                    next_node[prev] = n;
                end
                else
                begin
                    head_live[b] = 1'b1;
                    head_node[b] = n;
                end
                res.status = ST_CREATED;
                res.node_index = n;
            end
            else
            begin
                res.status = ST_FULL;
            end
        end
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                expected_rsps.push_back(table_access(in_data));
                accepted_reqs++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_reqs.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: response beat with none expected, actual %p",
                             $time, out_data);
                    errors++;
                end
                else
                begin
                    if (out_data !== expected_rsps[0])
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time,
                                 expected_rsps[0], out_data);
                        errors++;
                    end
                    if (expected_rsps[0].status == ST_FULL)
                        full_seen++;
                    void'(expected_rsps.pop_front());
                    checked_rsps++;
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog expired, %0d responses outstanding", $time,
                         expected_rsps.size());
                $display("spatial_hash_cell_table_unit verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_grid(int x, int y, int z);
        int vals[3];
        vals = '{x, y, z};
        wait_drained();
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_INDEX_WIDTH'(i);
            cfg_data <= CFG_WIDTH'(vals[i]);
            grid_log2[i] = CFG_WIDTH'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic req_t make_req(logic [1:0] a, logic [15:0] x, logic [15:0] y,
                                      logic [15:0] z);
        req_t r;
        r.action = a;
        r.cell_x = x;
        r.cell_y = y;
        r.cell_z = z;
        return r;
    endfunction

    // coordinates drawn from a small working set so that chains collide
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0: return 16'($urandom_range(7));
            1: return 16'($urandom_range(7)) << $urandom_range(15);
            2: return ~16'($urandom_range(7));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(int count, int insert_bias);
        logic [1:0] a;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < insert_bias)
                a = ACT_INSERT;
            else if (k < insert_bias + 25)
                a = ACT_REMOVE;
            else if (k < 97)
                a = ACT_LOOKUP;
            else
                a = ACT_SPARE;
            pending_reqs.push_back(make_req(a, pick_coord(), pick_coord(), pick_coord()));
        end
    endtask

    initial
    begin
        errors = 0;
        accepted_reqs = 0;
        checked_rsps = 0;
        full_seen = 0;
        send_idle_pct = 14;
        recv_idle_pct = 80;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < NBUCKETS; i++)
        begin
            head_live[i] = 1'b0;
            head_node[i] = '0;
        end
        for (int i = 0; i < NNODES; i++)
        begin
            coord_x[i] = '0;
            coord_y[i] = '0;
            coord_z[i] = '0;
            next_live[i] = 1'b0;
            next_node[i] = '0;
        end
        free_live = 1'b0;
        free_node = '0;
        fresh_used = 0;
        grid_log2 = '{3'd4, 3'd4, 3'd4};
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every action, unused code, found on insert
        pending_reqs.push_back(make_req(ACT_LOOKUP, 16'h7fff, 16'h8000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'h7fff, 16'h8000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'h7fff, 16'h8000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'h8000, 16'h7fff, 16'hffff));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'h0010, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'h0020, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_SPARE, 16'h0010, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_REMOVE, 16'h0010, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_REMOVE, 16'h0010, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_LOOKUP, 16'h0020, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'h0030, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_REMOVE, 16'h7fff, 16'h8000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_REMOVE, 16'h0030, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(ACT_INSERT, 16'hffff, 16'hffff, 16'hffff));
        pending_reqs.push_back(make_req(ACT_LOOKUP, 16'hffff, 16'hffff, 16'hffff));
        random_burst(300, 40);

        set_grid(0, 0, 0);
        random_burst(150, 40);
        set_grid(7, 7, 7);
        random_burst(200, 40);
        wait_drained();
        send_idle_pct = 80;
        recv_idle_pct = 14;
        set_grid(6, 3, 1);
        // fill the pool to exhaustion, then free some
        random_burst(1100, 90);
        random_burst(100, 10);
        set_grid(2, 6, 5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(200, 35);
        wait_drained();

        $display("covered %0d requests and %0d checked responses over five grid settings,",
                 accepted_reqs, checked_rsps);
        $display("pool exhaustion reached %0d times", full_seen);
        if (errors == 0)
            $display("spatial_hash_cell_table_unit verification clean");
        else
            $display("spatial_hash_cell_table_unit verification failed");
        $finish;
    end
endmodule
